FILE: rtl/lfrs_pkg.sv
// Shared types, command codes and header constants for the LED frame
// receive-and-scan block. Depends on nothing; every module in rtl/ uses it.
package lfrs_pkg;

    // Input request and result payloads
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] gray_byte;
        logic [3:0] row_select;
        logic       frame_start;
    } out_t;

    // Command codes
    localparam logic [1:0] CMD_SERIAL = 2'd0;
    localparam logic [1:0] CMD_SHIFT  = 2'd1;
    localparam logic [1:0] CMD_LATCH  = 2'd2;

    // Result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_LATCH = 1'b1;

    // Header matcher states: 1..5 mean R,G,B,L,E seen
    localparam logic [2:0] HDR_IDLE    = 3'd0;
    localparam logic [2:0] HDR_LOADING = 3'd6;

    localparam logic [7:0] BLANK_BYTE = 8'hFF;

    // Result queue between the front and the back
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One queued operation: latch or byte, with the raw store read data
    typedef struct packed {
        logic       kind;
        logic [3:0] row_select;
        logic       frame_start;
        logic       stored;     // byte was written since reset
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic [QCW-1:0] count;
    } back_status_t;

    // Expected byte for each header matcher state
    function automatic logic [7:0] header_byte(input logic [2:0] state);
        logic [7:0] b;
        unique case (state)
            3'd0:    b = 8'h52;  // R
            3'd1:    b = 8'h47;  // G
            3'd2:    b = 8'h42;  // B
            3'd3:    b = 8'h4C;  // L
            3'd4:    b = 8'h45;  // E
            3'd5:    b = 8'h44;  // D
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/led_frame_receive_and_scan.sv
// LED frame store with serial header loader and field scan-out.
// A request passes the read stage registers and then the result queue before its result is offered.
// Throughput: one request per cycle; the frame store read port and the
// 4-entry result queue set the pace, so requests stall only on output stall.
// Reset: control clears at once; no clearing pass runs, a fill count makes
// store bytes never written since reset read as 0xFF.
module led_frame_receive_and_scan #(
    parameter int NUM_FIELDS      = 4,
    parameter int BYTES_PER_FIELD = 192
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  lfrs_pkg::in_t  item,
    output logic           result_valid,
    input  logic           result_stall,
    output lfrs_pkg::out_t result
);

    logic                   accept;
    logic                   push;
    lfrs_pkg::op_t          op;
    lfrs_pkg::back_status_t status;

    // leave room for the request already in the read stage
    assign item_stall = (int'(status.count) + int'(push)) >= lfrs_pkg::QDEPTH;
    assign accept     = item_valid && !item_stall;

    lfrs_front #(
        .NUM_FIELDS      (NUM_FIELDS),
        .BYTES_PER_FIELD (BYTES_PER_FIELD)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .op     (op)
    );

    lfrs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .op           (op),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (int'(status.count) < lfrs_pkg::QDEPTH))
        else $error("result queue overflow");

    a_latch_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == lfrs_pkg::KIND_LATCH) |->
        (result.gray_byte == 8'h00 && !result.frame_start && $onehot0(result.row_select)))
        else $error("malformed latch result");

    a_byte_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == lfrs_pkg::KIND_BYTE) |->
        (result.row_select == 4'd0))
        else $error("byte result carries a row select");

endmodule

FILE: rtl/lfrs_front.sv
// Front end: takes requests, runs the header matcher, owns the frame store
// and scan counters, and issues result operations. Depends on lfrs_pkg.
module lfrs_front #(
    parameter int NUM_FIELDS      = 4,
    parameter int BYTES_PER_FIELD = 192
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  lfrs_pkg::in_t         item,
    output logic                  push,
    output lfrs_pkg::op_t         op
);

    localparam int FRAME_BYTES = NUM_FIELDS * BYTES_PER_FIELD;
    localparam int AW  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CW  = $clog2(FRAME_BYTES + 1);
    localparam int SPW = $clog2(BYTES_PER_FIELD + 1);
    localparam int FW  = $clog2(NUM_FIELDS + 1);

    logic [2:0]     hdr_reg, hdr_next;
    logic [CW-1:0]  wr_idx_reg, wr_idx_next;
    logic [CW-1:0]  filled_reg, filled_next;
    logic [CW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [SPW-1:0] shift_pos_reg, shift_pos_next;
    logic [FW-1:0]  field_reg, field_next;
    logic [FW-1:0]  pending_reg, pending_next;

    logic           s1_valid_reg, s1_valid_next;
    logic           s1_kind_reg, s1_kind_next;
    logic [3:0]     s1_row_reg, s1_row_next;
    logic           s1_fs_reg, s1_fs_next;
    logic           s1_stored_reg, s1_stored_next;

    logic [7:0]     mem [FRAME_BYTES];
    logic [7:0]     rd_data_reg;
    logic           wr_en, rd_en;
    logic [AW-1:0]  wr_addr, rd_addr;

    logic           wrap;
    logic [FW-1:0]  field_eff;
    logic [CW-1:0]  ptr_eff;
    logic [CW-1:0]  wr_inc;
    logic [SPW-1:0] sp_inc;

    always_comb
    begin
        hdr_next       = hdr_reg;
        wr_idx_next    = wr_idx_reg;
        filled_next    = filled_reg;
        rd_ptr_next    = rd_ptr_reg;
        shift_pos_next = shift_pos_reg;
        field_next     = field_reg;
        pending_next   = pending_reg;
        s1_valid_next  = 1'b0;
        s1_kind_next   = lfrs_pkg::KIND_BYTE;
        s1_row_next    = 4'd0;
        s1_fs_next     = 1'b0;
        s1_stored_next = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        // wrap from the last field back to field 0 on the next shift
        wrap      = (shift_pos_reg == '0) && (field_reg >= FW'(NUM_FIELDS));
        field_eff = wrap ? '0 : field_reg;
        ptr_eff   = wrap ? '0 : rd_ptr_reg;
        wr_inc    = wr_idx_reg + 1'b1;
        sp_inc    = shift_pos_reg + 1'b1;
        wr_addr   = wr_idx_reg[AW-1:0];
        rd_addr   = ptr_eff[AW-1:0];

        if (accept)
        begin
            case (item.command)
                lfrs_pkg::CMD_SERIAL:
                begin
                    if (hdr_reg >= lfrs_pkg::HDR_LOADING)
                    begin
                        wr_en       = 1'b1;
                        wr_idx_next = wr_inc;
                        if (wr_inc > filled_reg)
                        begin
                            filled_next = wr_inc;
                        end
                        if (wr_inc >= CW'(FRAME_BYTES))
                        begin
                            hdr_next = lfrs_pkg::HDR_IDLE;
                        end
                    end
                    else if (item.data_byte == lfrs_pkg::header_byte(hdr_reg))
                    begin
                        hdr_next = hdr_reg + 3'd1;
                        if (hdr_reg + 3'd1 == lfrs_pkg::HDR_LOADING)
                        begin
                            wr_idx_next = '0;
                        end
                    end
                    else
                    begin
                        hdr_next = lfrs_pkg::HDR_IDLE;
                    end
                end
                lfrs_pkg::CMD_SHIFT:
                begin
                    if (pending_reg == '0)
                    begin
                        rd_en          = 1'b1;
                        s1_valid_next  = 1'b1;
                        s1_fs_next     = wrap;
                        s1_stored_next = (ptr_eff < filled_reg);
                        rd_ptr_next    = ptr_eff + 1'b1;
                        if (sp_inc >= SPW'(BYTES_PER_FIELD))
                        begin
                            shift_pos_next = '0;
                            field_next     = field_eff + 1'b1;
                            pending_next   = field_eff + 1'b1;
                        end
                        else
                        begin
                            shift_pos_next = sp_inc;
                            field_next     = field_eff;
                        end
                    end
                end
                lfrs_pkg::CMD_LATCH:
                begin
                    if (pending_reg != '0)
                    begin
                        s1_valid_next = 1'b1;
                        s1_kind_next  = lfrs_pkg::KIND_LATCH;
                        if (int'(pending_reg) <= 4)
                        begin
                            s1_row_next = 4'(4'b0001 << (pending_reg - 1'b1));
                        end
                        pending_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg       <= lfrs_pkg::HDR_IDLE;
            wr_idx_reg    <= '0;
            filled_reg    <= '0;
            rd_ptr_reg    <= '0;
            shift_pos_reg <= '0;
            field_reg     <= '0;
            pending_reg   <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            hdr_reg       <= hdr_next;
            wr_idx_reg    <= wr_idx_next;
            filled_reg    <= filled_next;
            rd_ptr_reg    <= rd_ptr_next;
            shift_pos_reg <= shift_pos_next;
            field_reg     <= field_next;
            pending_reg   <= pending_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg   <= s1_kind_next;
        s1_row_reg    <= s1_row_next;
        s1_fs_reg     <= s1_fs_next;
        s1_stored_reg <= s1_stored_next;
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= item.data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign push           = s1_valid_reg;
    assign op.kind        = s1_kind_reg;
    assign op.row_select  = s1_row_reg;
    assign op.frame_start = s1_fs_reg;
    assign op.stored      = s1_stored_reg;
    assign op.data        = rd_data_reg;

endmodule

FILE: rtl/lfrs_back.sv
// Back end: result queue fed by the front, shapes and delivers results
// on the valid/stall output channel. Depends on lfrs_pkg.
module lfrs_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lfrs_pkg::op_t          op,
    output lfrs_pkg::back_status_t status,
    output logic                   result_valid,
    input  logic                   result_stall,
    output lfrs_pkg::out_t         result
);

    lfrs_pkg::op_t               q_reg [lfrs_pkg::QDEPTH];
    logic [lfrs_pkg::QPW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lfrs_pkg::QPW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lfrs_pkg::QCW-1:0]    count_reg, count_next;
    logic                        pop;
    lfrs_pkg::op_t               head;

    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign head         = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= op;
        end
    end

    // bytes never written since reset read as blank
    always_comb
    begin
        result.kind        = head.kind;
        result.row_select  = head.row_select;
        result.frame_start = head.frame_start;
        if (head.kind == lfrs_pkg::KIND_LATCH)
        begin
            result.gray_byte = 8'h00;
        end
        else
        begin
            result.gray_byte = head.stored ? head.data : lfrs_pkg::BLANK_BYTE;
        end
    end

    assign status.count = count_reg;

endmodule

FILE: dv/lfrs_scan_checker.sv
// Scoreboard for the LED frame receive-and-scan block: watches both channels,
// predicts each result from its own copy of the frame store and scan state.
// Depends on lfrs_pkg for the request and result payload types.
module lfrs_scan_checker #(
    parameter int NUM_FIELDS      = 4,
    parameter int BYTES_PER_FIELD = 192
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic           item_stall,
    input  lfrs_pkg::in_t  item,
    input  logic           result_valid,
    input  logic           result_stall,
    input  lfrs_pkg::out_t result,
    output int             mismatches,
    output int             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES = NUM_FIELDS * BYTES_PER_FIELD;

    // Header bytes: R G B L E D
    localparam logic [7:0] HEADER_SEQ [6] = '{8'h52, 8'h47, 8'h42, 8'h4C, 8'h45, 8'h44};

    logic [2:0] hdr_match;
    int         load_ptr;
    logic [7:0] frame_copy [FRAME_BYTES];
    int         field_idx;
    int         byte_pos;
    int         field_waiting;   // 0 = none, else number of the field awaiting latch

    lfrs_pkg::out_t pending_scan_results [$];
    lfrs_pkg::out_t want;
    lfrs_pkg::out_t got_next;

    function automatic bit predict_scan_output(input lfrs_pkg::in_t req,
                                               output lfrs_pkg::out_t res);
        int idx;
        res = '0;
        case (req.command)
            lfrs_pkg::CMD_SERIAL:
            begin
                if (hdr_match >= lfrs_pkg::HDR_LOADING)
                begin
                    if (load_ptr < FRAME_BYTES)
                        frame_copy[load_ptr] = req.data_byte;
                    load_ptr++;
                    if (load_ptr >= FRAME_BYTES)
                        hdr_match = lfrs_pkg::HDR_IDLE;
                end
                else if (req.data_byte == HEADER_SEQ[hdr_match])
                begin
                    hdr_match++;
                    if (hdr_match == lfrs_pkg::HDR_LOADING)
                        load_ptr = 0;
                end
                else
                begin
                    // wrong byte drops to idle and is not retried as a new R
                    hdr_match = lfrs_pkg::HDR_IDLE;
                end
                return 1'b0;
            end
            lfrs_pkg::CMD_SHIFT:
            begin
                if (field_waiting != 0)
                    return 1'b0;
                if (byte_pos == 0 && field_idx >= NUM_FIELDS)
                begin
                    field_idx = 0;
                    res.frame_start = 1'b1;
                end
                idx = byte_pos + BYTES_PER_FIELD * field_idx;
                res.kind      = lfrs_pkg::KIND_BYTE;
                res.gray_byte = (idx < FRAME_BYTES) ? frame_copy[idx] : 8'h00;
                byte_pos++;
                if (byte_pos >= BYTES_PER_FIELD)
                begin
                    byte_pos = 0;
                    field_idx++;
                    field_waiting = field_idx;
                end
                return 1'b1;
            end
            lfrs_pkg::CMD_LATCH:
            begin
                if (field_waiting == 0)
                    return 1'b0;
                res.kind       = lfrs_pkg::KIND_LATCH;
                res.row_select = (field_waiting <= 4) ? 4'(1 << (field_waiting - 1)) : 4'h0;
                field_waiting  = 0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void note_failure(input string what, input lfrs_pkg::out_t exp_r,
                                         input lfrs_pkg::out_t act_r);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s: expected kind=%0d gray=%02h row=%b fs=%0d, ",
                      "got kind=%0d gray=%02h row=%b fs=%0d"},
                     $realtime, what, exp_r.kind, exp_r.gray_byte, exp_r.row_select,
                     exp_r.frame_start, act_r.kind, act_r.gray_byte, act_r.row_select,
                     act_r.frame_start);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_match     = lfrs_pkg::HDR_IDLE;
            load_ptr      = 0;
            field_idx     = 0;
            byte_pos      = 0;
            field_waiting = 0;
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_copy[i] = lfrs_pkg::BLANK_BYTE;
            pending_scan_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_scan_results.size() == 0)
                begin
                    note_failure("result with no request behind it", '0, result);
                end
                else
                begin
                    want = pending_scan_results.pop_front();
                    if (want.kind !== result.kind || want.gray_byte !== result.gray_byte ||
                        want.row_select !== result.row_select ||
                        want.frame_start !== result.frame_start)
                        note_failure("result mismatch", want, result);
                end
            end
            if (item_valid && !item_stall)
            begin
                if (predict_scan_output(item, got_next))
                    pending_scan_results.push_back(got_next);
            end
            outstanding = pending_scan_results.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the LED frame receive-and-scan testbench: clock, reset, request
// stimulus and receiver stalls. Depends on lfrs_pkg, the block and lfrs_scan_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    localparam logic [7:0] HEADER_SEQ [6] = '{8'h52, 8'h47, 8'h42, 8'h4C, 8'h45, 8'h44};
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int BYTES_PER_FIELD_TB = 192;
    localparam int FRAME_BYTES_TB     = 4 * BYTES_PER_FIELD_TB;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    lfrs_pkg::in_t  item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    lfrs_pkg::out_t result;

    int mismatches;
    int outstanding;
    int sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always #2 clk = ~clk;

    led_frame_receive_and_scan dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    lfrs_scan_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{command: cmd, data_byte: b};
        forever
        begin
            @(negedge clk);
            if (!item_stall)
                break;
        end
        @(posedge clk);
        sent++;
    endtask

    // Hold off requests until every predicted result has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (outstanding == 0)
                break;
        end
        @(posedge clk);
    endtask

    task automatic send_header(input int bad_pos);
        for (int i = 0; i < 6; i++)
        begin
            if (i == bad_pos)
                send_request(lfrs_pkg::CMD_SERIAL,
                             HEADER_SEQ[i] ^ 8'($urandom_range(1, 255)));
            else
                send_request(lfrs_pkg::CMD_SERIAL, HEADER_SEQ[i]);
        end
    endtask

    task automatic run_episode();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // scan one field, then latch it most of the time
            n = ($urandom_range(9) < 7) ? BYTES_PER_FIELD_TB
                                        : $urandom_range(1, BYTES_PER_FIELD_TB);
            repeat (n)
                send_request(lfrs_pkg::CMD_SHIFT, 8'($urandom_range(255)));
            if ($urandom_range(99) < 85)
                send_request(lfrs_pkg::CMD_LATCH, 8'($urandom_range(255)));
        end
        else if (pick < 70)
        begin
            repeat ($urandom_range(1, 200))
                send_request(lfrs_pkg::CMD_SERIAL, 8'($urandom_range(255)));
        end
        else if (pick < 90)
        begin
            send_header(($urandom_range(3) == 0) ? int'($urandom_range(5)) : -1);
            repeat ($urandom_range(200))
                send_request(lfrs_pkg::CMD_SERIAL, 8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 82;

        // blank store after reset, latch with nothing pending, unused command
        send_request(lfrs_pkg::CMD_SHIFT, 8'h00);
        send_request(lfrs_pkg::CMD_LATCH, 8'hFF);
        send_request(CMD_UNUSED, 8'hFF);
        send_request(lfrs_pkg::CMD_SERIAL, 8'h00);
        send_request(lfrs_pkg::CMD_SERIAL, 8'hFF);
        // R R G B: second R drops to idle and is not taken as a new R
        send_request(lfrs_pkg::CMD_SERIAL, HEADER_SEQ[0]);
        send_request(lfrs_pkg::CMD_SERIAL, HEADER_SEQ[0]);
        send_request(lfrs_pkg::CMD_SERIAL, HEADER_SEQ[1]);
        send_request(lfrs_pkg::CMD_SERIAL, HEADER_SEQ[2]);
        // header broken at its last byte, then a stray D
        send_header(5);
        send_request(lfrs_pkg::CMD_SERIAL, HEADER_SEQ[5]);
        send_request(CMD_UNUSED, 8'h00);
        send_request(lfrs_pkg::CMD_LATCH, 8'h00);
        send_request(lfrs_pkg::CMD_SHIFT, 8'hFF);

        // one full frame load with random content
        send_header(-1);
        repeat (FRAME_BYTES_TB)
            send_request(lfrs_pkg::CMD_SERIAL, 8'($urandom_range(255)));
        while (sent < 950)
            run_episode();
        drain_results();

        send_idle_pct = 82;
        recv_idle_pct = 20;
        while (sent < 1300)
            run_episode();
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sent < 1600)
            run_episode();
        drain_results();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
